// ===== rtl/core/torq_pkg.sv =====
package torq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int MAX_PROCESSES_DEF = 64;

  // channel widths that follow from the default sizes
  localparam int PID_W_DEF = $clog2(MAX_PROCESSES_DEF);
  localparam int CNT_W_DEF = $clog2(QUEUE_DEPTH_DEF + 1);

  // fixed field widths
  localparam int STAMP_W = 32;
  localparam int PCNT_W  = 7;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 7'd64;

  // register index as seen on paddr[2]
  localparam logic REG_PROCESS_COUNT = 1'b0;

  // command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPID = 2'd3;

  // shift control broadcast to every cell of the row
  typedef struct packed {
    logic insert;
    logic remove;
  } torq_op_t;

endpackage

// ===== rtl/core/torq_in_if.sv =====
interface torq_in_if import torq_pkg::*; #(
  parameter int PID_W = PID_W_DEF
);
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PID_W-1:0]   pid;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, output cmd, output pid, output timestamp, input ready);
  modport sink   (input valid, input cmd, input pid, input timestamp, output ready);
endinterface

// ===== rtl/core/torq_out_if.sv =====
interface torq_out_if import torq_pkg::*; #(
  parameter int PID_W = PID_W_DEF,
  parameter int CNT_W = CNT_W_DEF
);
  logic               valid;
  logic               ready;
  logic               head_valid;
  logic [PID_W-1:0]   grant_pid;
  logic [STAMP_W-1:0] grant_timestamp;
  logic [CNT_W-1:0]   queue_count;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output head_valid, output grant_pid,
                  output grant_timestamp, output queue_count, output status,
                  input ready);
  modport sink   (input valid, input head_valid, input grant_pid,
                  input grant_timestamp, input queue_count, input status,
                  output ready);
endinterface

// ===== rtl/core/torq_cell.sv =====
module torq_cell import torq_pkg::*; #(
  parameter int PID_W = 6
) (
  input  logic               clk,
  input  torq_op_t           op,
  input  logic               occupied,
  input  logic [PID_W-1:0]   new_pid,
  input  logic [STAMP_W-1:0] new_stamp,
  input  logic               left_ahead,
  input  logic [PID_W-1:0]   left_pid,
  input  logic [STAMP_W-1:0] left_stamp,
  input  logic [PID_W-1:0]   right_pid,
  input  logic [STAMP_W-1:0] right_stamp,
  output logic               ahead,
  output logic [PID_W-1:0]   pid,
  output logic [STAMP_W-1:0] stamp,
  output logic [PID_W-1:0]   pid_nxt,
  output logic [STAMP_W-1:0] stamp_nxt
);

  logic [PID_W-1:0]   pid_r;
  logic [STAMP_W-1:0] stamp_r;

  // held entry stays in front of the new word: lower stamp, or same stamp and pid not above
  assign ahead = occupied &&
                 ((stamp_r < new_stamp) || ((stamp_r == new_stamp) && (pid_r <= new_pid)));

  // keep, take the new word, shift right on insert, shift left on release
  always_comb begin
    pid_nxt   = pid_r;
    stamp_nxt = stamp_r;
    if (op.insert) begin
      if (!ahead) begin
        if (left_ahead) begin
          pid_nxt   = new_pid;
          stamp_nxt = new_stamp;
        end else begin
          pid_nxt   = left_pid;
          stamp_nxt = left_stamp;
        end
      end
    end else if (op.remove) begin
      pid_nxt   = right_pid;
      stamp_nxt = right_stamp;
    end
  end

  always_ff @(posedge clk) begin
    pid_r   <= pid_nxt;
    stamp_r <= stamp_nxt;
  end

  assign pid   = pid_r;
  assign stamp = stamp_r;

endmodule

// ===== rtl/core/timestamp_ordered_request_queue.sv =====
// Sorted request queue for Lamport mutual exclusion, built as a row of QUEUE_DEPTH cells.
// Each word on in_ch is a request (cmd 0: insert pid/timestamp, lower timestamp first,
// lower pid first on equal timestamps, behind equal entries) or a release (cmd 1: drop the
// head). Every word gives one result on out_ch the cycle after it is taken: the head after
// the word, the pending count and a status (0 ok, 1 full, 2 release on empty, 3 pid not below
// process_count or MAX_PROCESSES); a rejected word leaves the queue as it was. The queue
// takes one word per cycle unless stalled: every cell compares its entry with the incoming
// word and shifts in the same cycle, and a single output register lets the next word in while
// the current result is being taken. No clearing pass is needed after reset. process_count
// lies at byte address 0 of the APB port, resets to 64, and must be written only while idle.
module timestamp_ordered_request_queue import torq_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  torq_in_if.sink           in_ch,
  torq_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int PID_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = ((PID_W > PCNT_W) ? PID_W : PCNT_W) + 1;
  localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_PROCESSES);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // configuration register
  logic [PCNT_W-1:0] process_count_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROCESS_COUNT) ?
                  DATA_W'(process_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_count_r <= PCNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_PROCESS_COUNT)) begin
      process_count_r <= pwdata[PCNT_W-1:0];
    end
  end

  // handshake: output register parts the two sides, nothing taken during reset
  logic out_valid_r;
  logic take;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  // command decode and status
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [LIM_W-1:0]  pid_ext;
  logic              pid_ok;
  logic [STAT_W-1:0] status;
  torq_op_t          op;

  assign pid_ext = LIM_W'(in_ch.pid);
  assign pid_ok  = (pid_ext < LIM_W'(process_count_r)) && (pid_ext < MAX_LIM);

  always_comb begin
    op        = '0;
    status    = ST_OK;
    count_nxt = count_r;
    if (take) begin
      case (in_ch.cmd)
        CMD_REQUEST: begin
          if (!pid_ok) begin
            status = ST_BADPID;
          end else if (count_r == FULL_CNT) begin
            status = ST_FULL;
          end else begin
            op.insert = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_RELEASE: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            op.remove = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells, head at index 0
  logic               ahead     [QUEUE_DEPTH];
  logic [PID_W-1:0]   cpid      [QUEUE_DEPTH];
  logic [STAMP_W-1:0] cstamp    [QUEUE_DEPTH];
  logic [PID_W-1:0]   cpid_nxt  [QUEUE_DEPTH];
  logic [STAMP_W-1:0] cstamp_nxt[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic               occ;
    logic               l_ahead;
    logic [PID_W-1:0]   l_pid;
    logic [STAMP_W-1:0] l_stamp;
    logic [PID_W-1:0]   r_pid;
    logic [STAMP_W-1:0] r_stamp;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_ahead = 1'b1;
      assign l_pid   = in_ch.pid;
      assign l_stamp = in_ch.timestamp;
    end else begin : g_inner
      assign l_ahead = ahead[i-1];
      assign l_pid   = cpid[i-1];
      assign l_stamp = cstamp[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_pid   = cpid[i];
      assign r_stamp = cstamp[i];
    end else begin : g_body
      assign r_pid   = cpid[i+1];
      assign r_stamp = cstamp[i+1];
    end

    torq_cell #(
      .PID_W(PID_W)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .occupied   (occ),
      .new_pid    (in_ch.pid),
      .new_stamp  (in_ch.timestamp),
      .left_ahead (l_ahead),
      .left_pid   (l_pid),
      .left_stamp (l_stamp),
      .right_pid  (r_pid),
      .right_stamp(r_stamp),
      .ahead      (ahead[i]),
      .pid        (cpid[i]),
      .stamp      (cstamp[i]),
      .pid_nxt    (cpid_nxt[i]),
      .stamp_nxt  (cstamp_nxt[i])
    );
  end

  // result register
  logic               head_valid_r;
  logic [PID_W-1:0]   grant_pid_r;
  logic [STAMP_W-1:0] grant_stamp_r;
  logic [CNT_W-1:0]   queue_count_r;
  logic [STAT_W-1:0]  status_r;
  logic               head_nz;

  assign head_nz = (count_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      head_valid_r  <= head_nz;
      grant_pid_r   <= head_nz ? cpid_nxt[0] : '0;
      grant_stamp_r <= head_nz ? cstamp_nxt[0] : '0;
      queue_count_r <= count_nxt;
      status_r      <= status;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.head_valid      = head_valid_r;
  assign out_ch.grant_pid       = grant_pid_r;
  assign out_ch.grant_timestamp = grant_stamp_r;
  assign out_ch.queue_count     = queue_count_r;
  assign out_ch.status          = status_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import torq_pkg::*; ();

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int PROCS       = MAX_PROCESSES_DEF;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_WORDS = 225;
  localparam int PRINT_MAX   = 40;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         pid;
    logic [STAMP_W-1:0] stamp;
  } lock_word_t;

  typedef struct packed {
    logic               head_valid;
    logic [5:0]         grant_pid;
    logic [STAMP_W-1:0] grant_stamp;
    logic [4:0]         count;
    logic [STAT_W-1:0]  status;
  } grant_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  torq_in_if  in_bus ();
  torq_out_if out_bus ();

  timestamp_ordered_request_queue DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // pending words, expected grants and bookkeeping
  lock_word_t word_q [$];
  grant_t     grant_q [$];
  grant_t     want_grant;
  int         words_pushed   = 0;
  int         grants_checked = 0;
  int         mismatches     = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  int         hold_asked     = 0;
  int         hold_served    = 0;
  int         hold_left      = 0;
  int         stall_cycles   = 0;
  logic       in_acc         = 1'b0;

  // shadow copy of the sorted queue and the process count
  logic [5:0]         held_pid   [DEPTH];
  logic [STAMP_W-1:0] held_stamp [DEPTH];
  int                 held_len   = 0;
  int                 proc_count = PCNT_RESET;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // apply one word to the shadow queue and return the grant it leaves
  function automatic grant_t apply_word(lock_word_t w);
    grant_t g;
    int     limit;
    int     pos;
    int     k;
    limit = (proc_count < PROCS) ? proc_count : PROCS;
    g = '0;
    g.status = ST_OK;
    if (w.cmd == CMD_REQUEST) begin
      if (int'(w.pid) >= limit) begin
        g.status = ST_BADPID;
      end else if (held_len >= DEPTH) begin
        g.status = ST_FULL;
      end else begin
        // skip entries with a lower stamp, or same stamp and pid not above
        pos = 0;
        while (pos < held_len && (held_stamp[pos] < w.stamp ||
               (held_stamp[pos] == w.stamp && held_pid[pos] <= w.pid)))
          pos++;
        for (k = held_len; k > pos; k--) begin
          held_pid[k]   = held_pid[k-1];
          held_stamp[k] = held_stamp[k-1];
        end
        held_pid[pos]   = w.pid;
        held_stamp[pos] = w.stamp;
        held_len++;
      end
    end else if (held_len == 0) begin
      g.status = ST_EMPTY;
    end else begin
      for (k = 0; k + 1 < held_len; k++) begin
        held_pid[k]   = held_pid[k+1];
        held_stamp[k] = held_stamp[k+1];
      end
      held_len--;
    end
    if (held_len > 0) begin
      g.head_valid  = 1'b1;
      g.grant_pid   = held_pid[0];
      g.grant_stamp = held_stamp[0];
    end
    g.count = 5'(held_len);
    return g;
  endfunction

  // word driver: next word goes out once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_bus.valid || in_acc)) begin
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid <= 1'b1;
        {in_bus.cmd, in_bus.pid, in_bus.timestamp} <= word_q.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    in_acc <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready)
      grant_q.push_back(apply_word('{cmd: in_bus.cmd, pid: in_bus.pid,
                                     stamp: in_bus.timestamp}));
    if (rst_n && out_bus.valid && out_bus.ready) begin
      grants_checked++;
      if (grant_q.size() == 0) begin
        note_mismatch("result with none expected", out_bus.queue_count, 0);
      end else begin
        want_grant = grant_q.pop_front();
        if (out_bus.head_valid !== want_grant.head_valid)
          note_mismatch("head_valid", out_bus.head_valid, want_grant.head_valid);
        if (out_bus.grant_pid !== want_grant.grant_pid)
          note_mismatch("grant_pid", out_bus.grant_pid, want_grant.grant_pid);
        if (out_bus.grant_timestamp !== want_grant.grant_stamp)
          note_mismatch("grant_timestamp", out_bus.grant_timestamp,
                        want_grant.grant_stamp);
        if (out_bus.queue_count !== want_grant.count)
          note_mismatch("queue_count", out_bus.queue_count, want_grant.count);
        if (out_bus.status !== want_grant.status)
          note_mismatch("status", out_bus.status, want_grant.status);
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || psel || (in_bus.valid && in_bus.ready) ||
        (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input logic cmd, input logic [5:0] pid,
                           input logic [STAMP_W-1:0] stamp);
    word_q.push_back('{cmd: cmd, pid: pid, stamp: stamp});
    words_pushed++;
  endtask

  task automatic wait_drained();
    while (grants_checked < words_pushed) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // one apb transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_PROCESS_COUNT, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic readback_check(input int value);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== DATA_W'(value))
      note_mismatch("process_count readback", rd, value);
  endtask

  task automatic set_process_count(input int value);
    logic [DATA_W-1:0] rd;
    wait_drained();
    apb_xfer(1'b1, DATA_W'(value), rd);
    proc_count = value;
    readback_check(value);
  endtask

  // bursts of well-formed requests then releases, with some noise words
  task automatic queue_random(input int n);
    int                 limit;
    int                 reqs;
    int                 rels;
    int                 left;
    logic [STAMP_W-1:0] lamport_clock;
    limit = (proc_count < PROCS) ? proc_count : PROCS;
    lamport_clock = $urandom;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        push_word(1'($urandom_range(1)), 6'($urandom_range(63)),
                  ($urandom_range(3) == 0) ? '0 :
                  ($urandom_range(2) == 0) ? '1 : $urandom);
        left--;
      end else begin
        reqs = $urandom_range(1, 20);
        rels = $urandom_range(1, 16);
        repeat (reqs) begin
          // small steps keep many equal stamps in flight
          lamport_clock += $urandom_range(3);
          push_word(CMD_REQUEST,
                    6'((limit > 0) ? $urandom_range(limit - 1) : $urandom_range(63)),
                    ($urandom_range(9) == 0) ? $urandom : lamport_clock);
        end
        repeat (rels) push_word(CMD_RELEASE, 6'($urandom_range(63)), $urandom);
        left -= reqs + rels;
      end
    end
  endtask

  initial begin
    int i;
    int ph;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = CMD_REQUEST;
    in_bus.pid       = '0;
    in_bus.timestamp = '0;
    out_bus.ready    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    readback_check(PCNT_RESET);
    send_idle_pct = 12;
    recv_idle_pct = 69;

    // directed: empty release, extremes, ties, fill to full, two releases
    push_word(CMD_RELEASE, '0, '0);
    push_word(CMD_REQUEST, 6'd0, '0);
    push_word(CMD_REQUEST, 6'd63, '1);
    push_word(CMD_REQUEST, 6'd5, 32'd100);
    push_word(CMD_REQUEST, 6'd3, 32'd100);
    push_word(CMD_REQUEST, 6'd5, 32'd100);
    push_word(CMD_REQUEST, 6'd0, '0);
    for (i = 10; i < 20; i++) push_word(CMD_REQUEST, 6'(i), 32'(200 + i));
    push_word(CMD_REQUEST, 6'd1, 32'd1);
    push_word(CMD_RELEASE, 6'd63, '1);
    push_word(CMD_RELEASE, '0, '0);

    // smallest process count, then zero which rejects every request
    set_process_count(1);
    push_word(CMD_REQUEST, 6'd1, 32'd50);
    push_word(CMD_REQUEST, 6'd0, 32'd50);
    set_process_count(0);
    push_word(CMD_REQUEST, 6'd0, 32'd7);
    push_word(CMD_RELEASE, '0, '0);

    // random phases over several process counts and idle patterns
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_process_count(PROCS);
        1: set_process_count(1);
        2: set_process_count($urandom_range(2, PROCS - 1));
        3: set_process_count(127);
        4: set_process_count($urandom_range(1, PROCS));
        default: set_process_count(PROCS);
      endcase
      send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 69 : 0;
      recv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 12 : 0;
      queue_random(PHASE_WORDS);
      if (ph == 0 || ph == 4) hold_asked++;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (grant_q.size() != 0)
      note_mismatch("results never seen", grant_q.size(), 0);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
